// ----- hw/rtl/tpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared constants and types for the triangle plane clipper.
// ----------------------------------------------------------------------------
package tpc_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int TAG_BITS_DEF   = 24;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 8'd3;

    localparam logic signed [15:0] NORMAL_X_RST = 16'sd16384;
    localparam logic signed [15:0] NORMAL_Y_RST = 16'sd0;
    localparam logic signed [15:0] NORMAL_Z_RST = 16'sd0;
    localparam logic signed [31:0] OFFSET_RST   = 32'sd0;

    // What the output stage does with a finished item.
    typedef enum logic [1:0] {
        MODE_DROP,
        MODE_PASS,
        MODE_ONE_IN,
        MODE_TWO_IN
    } mode_t;

endpackage

// ----- hw/rtl/tpc_div_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_div_step
// One registered restoring-division step: produces one quotient bit.
// ----------------------------------------------------------------------------
module tpc_div_step
    import tpc_pkg::*;
#(
    parameter int RW = 52,
    parameter int QW = 29
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [RW-1:0] r_in,
    input  logic [RW-1:0] d_in,
    input  logic [QW-1:0] q_in,
    output logic [RW-1:0] r_out,
    output logic [RW-1:0] d_out,
    output logic [QW-1:0] q_out
);

    logic [RW-1:0] r_shift;
    logic          fits;

    assign r_shift = {r_in[RW-2:0], 1'b0};
    assign fits    = (r_shift >= d_in);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_out <= fits ? (r_shift - d_in) : r_shift;
            d_out <= d_in;
            q_out <= {q_in[QW-2:0], fits};
        end
    end

endmodule

// ----- hw/rtl/triangle_plane_clip_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_plane_clip_core
// Clips a Q16.16 triangle against the plane n.p + d >= 0.
// ----------------------------------------------------------------------------
// The core accepts one triangle per cycle while it is not stalled and returns
// zero, one or two triangles for it; an item that yields two triangles holds
// the output until the second has been taken, and the input is stalled
// meanwhile. The cut-parameter divider produces T_FRAC quotient bits
// (T_FRAC = 61 - COORD_BITS, or 30 below 31 bits), one per pipeline stage.
// The whole pipeline stalls together when the output is held, so no
// transaction is lost or repeated. Configuration writes are always accepted
// and must only be issued while the core is idle.
module triangle_plane_clip_core
    import tpc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF,
    localparam int TDATA_W   = ((9 * COORD_BITS + TAG_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, source_tag, zero pad
    input  logic [TDATA_W-1:0]    s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // out_a_x .. out_c_z, out_tag, zero pad
    output logic [TDATA_W-1:0]    m_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CB   = COORD_BITS;
    localparam int TB   = TAG_BITS;
    localparam int PW   = CB + 16;
    localparam int DROP = (CB > 44) ? (CB - 44) : 0;
    localparam int PDW  = PW - DROP;
    localparam int SUMW = PDW + 2;
    localparam int OFW  = 47 - DROP;
    localparam int DW   = ((SUMW > OFW) ? SUMW : OFW) + 1;
    localparam int RW   = DW + 2;
    localparam int TF   = (CB >= 31) ? (61 - CB) : 30;
    localparam int MW   = TF + CB + 3;
    localparam int TRW  = 9 * CB;

    typedef logic [2:0][CB-1:0] vtx_t;
    typedef logic signed [DW-1:0] dist_t;

    typedef struct packed {
        logic          special;
        logic [TF:0]   tspec;
        logic [RW-1:0] r;
        logic [RW-1:0] d;
    } edge_t;

    typedef struct packed {
        vtx_t [2:0]       verts;
        logic [TB-1:0]    tag;
        mode_t            mode;
        logic [1:0]       special;
        logic [1:0][TF:0] tspec;
    } side_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    logic signed [31:0] off_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg  <= NORMAL_X_RST;
            ny_reg  <= NORMAL_Y_RST;
            nz_reg  <= NORMAL_Z_RST;
            off_reg <= OFFSET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NORMAL_X:     nx_reg  <= cfg_data[15:0];
                REG_NORMAL_Y:     ny_reg  <= cfg_data[15:0];
                REG_NORMAL_Z:     nz_reg  <= cfg_data[15:0];
                REG_PLANE_OFFSET: off_reg <= cfg_data[31:0];
                default:          ;
            endcase
        end
    end

    logic adv;
    assign s_axis_tready = adv;

    // ------------------------------------------------------------------
    // Stage 0: input register
    // ------------------------------------------------------------------
    logic          s0_valid_reg;
    vtx_t [2:0]    s0_tri_reg;
    logic [TB-1:0] s0_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (adv)
            s0_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_tri_reg <= s_axis_tdata[TRW-1:0];
            s0_tag_reg <= s_axis_tdata[TRW +: TB];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: nine products with the normal
    // ------------------------------------------------------------------
    logic                  s1_valid_reg;
    vtx_t [2:0]            s1_tri_reg;
    logic [TB-1:0]         s1_tag_reg;
    logic signed [PDW-1:0] s1_prod_reg [3][3];
    logic signed [PW-1:0]  nrm [3];

    assign nrm[0] = PW'(nx_reg);
    assign nrm[1] = PW'(ny_reg);
    assign nrm[2] = PW'(nz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tri_reg <= s0_tri_reg;
            s1_tag_reg <= s0_tag_reg;
            for (int v = 0; v < 3; v++)
                for (int k = 0; k < 3; k++)
                    s1_prod_reg[v][k] <= PDW'((PW'($signed(s0_tri_reg[v][k])) * nrm[k])
                                              >>> DROP);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: signed distances
    // ------------------------------------------------------------------
    logic          s2_valid_reg;
    vtx_t [2:0]    s2_tri_reg;
    logic [TB-1:0] s2_tag_reg;
    dist_t         s2_dist_reg [3];
    dist_t         off_term;

    assign off_term = DW'(off_reg) <<< (14 - DROP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_tri_reg <= s1_tri_reg;
            s2_tag_reg <= s1_tag_reg;
            for (int v = 0; v < 3; v++)
                s2_dist_reg[v] <= DW'(s1_prod_reg[v][0]) + DW'(s1_prod_reg[v][1])
                                + DW'(s1_prod_reg[v][2]) + off_term;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: classify, rotate and set up both edge divisions
    // ------------------------------------------------------------------
    function automatic edge_t edge_prep(input dist_t ds, input dist_t de);
        logic signed [DW:0] num;
        logic signed [DW:0] den;
        edge_t              e;
        num       = (DW+1)'(ds);
        den       = (DW+1)'(ds) - (DW+1)'(de);
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        e.special = 1'b1;
        e.tspec   = '0;
        e.r       = '0;
        e.d       = RW'(1);
        if (den == 0)
            e.tspec = (TF+1)'(1) << (TF - 1);
        else if (num <= 0)
            e.tspec = '0;
        else if (num >= den)
            e.tspec = (TF+1)'(1) << TF;
        else
        begin
            e.special = 1'b0;
            e.r       = RW'(num);
            e.d       = RW'(den);
        end
        return e;
    endfunction

    logic [2:0] vtx_in;
    logic [1:0] in_count;
    logic       one_in;
    logic [1:0] rot;
    mode_t      mode_c;
    vtx_t [2:0] rot_tri;
    dist_t      rd [3];
    edge_t      edge0_c, edge1_c;

    always_comb
    begin
        for (int v = 0; v < 3; v++)
            vtx_in[v] = (s2_dist_reg[v] >= 0);
        in_count = 2'(vtx_in[0]) + 2'(vtx_in[1]) + 2'(vtx_in[2]);
        one_in   = (in_count == 2'd1);
        if (vtx_in[0] == one_in)
            rot = 2'd0;
        else if (vtx_in[1] == one_in)
            rot = 2'd1;
        else
            rot = 2'd2;
        case (in_count)
            2'd0:    mode_c = MODE_DROP;
            2'd1:    mode_c = MODE_ONE_IN;
            2'd2:    mode_c = MODE_TWO_IN;
            default: mode_c = MODE_PASS;
        endcase
        if (mode_c == MODE_PASS)
            rot = 2'd0;
        case (rot)
            2'd1:
            begin
                rot_tri = {s2_tri_reg[0], s2_tri_reg[2], s2_tri_reg[1]};
                rd[0] = s2_dist_reg[1];
                rd[1] = s2_dist_reg[2];
                rd[2] = s2_dist_reg[0];
            end
            2'd2:
            begin
                rot_tri = {s2_tri_reg[1], s2_tri_reg[0], s2_tri_reg[2]};
                rd[0] = s2_dist_reg[2];
                rd[1] = s2_dist_reg[0];
                rd[2] = s2_dist_reg[1];
            end
            default:
            begin
                rot_tri = s2_tri_reg;
                rd[0] = s2_dist_reg[0];
                rd[1] = s2_dist_reg[1];
                rd[2] = s2_dist_reg[2];
            end
        endcase
        edge0_c = edge_prep(rd[0], rd[1]);
        edge1_c = edge_prep(rd[2], rd[0]);
    end

    logic          s3_valid_reg;
    side_t         s3_side_reg;
    logic [RW-1:0] s3_r_reg [2];
    logic [RW-1:0] s3_d_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_side_reg.verts    <= rot_tri;
            s3_side_reg.tag      <= s2_tag_reg;
            s3_side_reg.mode     <= mode_c;
            s3_side_reg.special  <= {edge1_c.special, edge0_c.special};
            s3_side_reg.tspec[0] <= edge0_c.tspec;
            s3_side_reg.tspec[1] <= edge1_c.tspec;
            s3_r_reg[0]          <= edge0_c.r;
            s3_r_reg[1]          <= edge1_c.r;
            s3_d_reg[0]          <= edge0_c.d;
            s3_d_reg[1]          <= edge1_c.d;
        end
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage for both edges
    // ------------------------------------------------------------------
    logic [RW-1:0] div_r [TF+1][2];
    logic [RW-1:0] div_d [TF+1][2];
    logic [TF-1:0] div_q [TF+1][2];
    logic          dv_valid_reg [1:TF];
    side_t         dv_side_reg  [1:TF];

    for (genvar j = 0; j < 2; j++)
    begin : g_lane_in
        assign div_r[0][j] = s3_r_reg[j];
        assign div_d[0][j] = s3_d_reg[j];
        assign div_q[0][j] = '0;
    end

    for (genvar i = 0; i < TF; i++)
    begin : g_div
        for (genvar j = 0; j < 2; j++)
        begin : g_lane
            tpc_div_step #(
                .RW (RW),
                .QW (TF)
            ) u_step (
                .clk   (clk),
                .en    (adv),
                .r_in  (div_r[i][j]),
                .d_in  (div_d[i][j]),
                .q_in  (div_q[i][j]),
                .r_out (div_r[i+1][j]),
                .d_out (div_d[i+1][j]),
                .q_out (div_q[i+1][j])
            );
        end

        logic  src_valid;
        side_t src_side;

        if (i == 0)
        begin : g_first
            assign src_valid = s3_valid_reg;
            assign src_side  = s3_side_reg;
        end
        else
        begin : g_next
            assign src_valid = dv_valid_reg[i];
            assign src_side  = dv_side_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[i+1] <= 1'b0;
            else if (adv)
                dv_valid_reg[i+1] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                dv_side_reg[i+1] <= src_side;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: final cut parameters and edge deltas
    // ------------------------------------------------------------------
    side_t             dv_last;
    logic              s4_valid_reg;
    vtx_t [2:0]        s4_tri_reg;
    logic [TB-1:0]     s4_tag_reg;
    mode_t             s4_mode_reg;
    logic [TF:0]       s4_t_reg    [2];
    logic signed [CB:0] s4_diff_reg [2][3];

    assign dv_last = dv_side_reg[TF];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (adv)
            s4_valid_reg <= dv_valid_reg[TF];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_tri_reg  <= dv_last.verts;
            s4_tag_reg  <= dv_last.tag;
            s4_mode_reg <= dv_last.mode;
            for (int j = 0; j < 2; j++)
                s4_t_reg[j] <= dv_last.special[j] ? dv_last.tspec[j]
                                                  : {1'b0, div_q[TF][j]};
            // First cut runs A to B, second runs C to A.
            for (int k = 0; k < 3; k++)
            begin
                s4_diff_reg[0][k] <= (CB+1)'($signed(dv_last.verts[1][k]))
                                   - (CB+1)'($signed(dv_last.verts[0][k]));
                s4_diff_reg[1][k] <= (CB+1)'($signed(dv_last.verts[0][k]))
                                   - (CB+1)'($signed(dv_last.verts[2][k]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: interpolation products
    // ------------------------------------------------------------------
    logic                 s5_valid_reg;
    vtx_t [2:0]           s5_tri_reg;
    logic [TB-1:0]        s5_tag_reg;
    mode_t                s5_mode_reg;
    logic signed [MW-1:0] s5_prod_reg [2][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (adv)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_tri_reg  <= s4_tri_reg;
            s5_tag_reg  <= s4_tag_reg;
            s5_mode_reg <= s4_mode_reg;
            for (int j = 0; j < 2; j++)
                for (int k = 0; k < 3; k++)
                    s5_prod_reg[j][k] <= MW'($signed({1'b0, s4_t_reg[j]}))
                                       * MW'(s4_diff_reg[j][k]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: rounded cut points, held here until emitted
    // ------------------------------------------------------------------
    localparam logic signed [MW-1:0] HALF = MW'(1) <<< (TF - 1);

    logic          s6_valid_reg;
    vtx_t [2:0]    s6_tri_reg;
    logic [TB-1:0] s6_tag_reg;
    mode_t         s6_mode_reg;
    vtx_t [1:0]    s6_pt_reg;
    logic          second_reg;
    logic          second_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (adv)
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_tri_reg  <= s5_tri_reg;
            s6_tag_reg  <= s5_tag_reg;
            s6_mode_reg <= s5_mode_reg;
            for (int k = 0; k < 3; k++)
            begin
                s6_pt_reg[0][k] <= CB'((s5_prod_reg[0][k] + HALF) >>> TF) + s5_tri_reg[0][k];
                s6_pt_reg[1][k] <= CB'((s5_prod_reg[1][k] + HALF) >>> TF) + s5_tri_reg[2][k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register and triangle sequencing
    // ------------------------------------------------------------------
    logic              out_load;
    logic              emit;
    logic              consume;
    vtx_t [2:0]        sel_tri;
    logic              sel_last;
    logic              m_valid_reg;
    logic              m_last_reg;
    logic [TDATA_W-1:0] m_data_reg;

    assign out_load = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        emit     = 1'b0;
        consume  = 1'b0;
        sel_tri  = s6_tri_reg;
        sel_last = 1'b1;
        case (s6_mode_reg)
            MODE_DROP:
            begin
                consume = 1'b1;
            end
            MODE_PASS:
            begin
                emit    = out_load;
                consume = out_load;
            end
            MODE_ONE_IN:
            begin
                emit    = out_load;
                consume = out_load;
                sel_tri = {s6_pt_reg[1], s6_pt_reg[0], s6_tri_reg[0]};
            end
            default:
            begin
                emit    = out_load;
                consume = out_load && second_reg;
                if (second_reg)
                    sel_tri = {s6_pt_reg[1], s6_tri_reg[2], s6_pt_reg[0]};
                else
                begin
                    sel_tri  = {s6_tri_reg[2], s6_tri_reg[1], s6_pt_reg[0]};
                    sel_last = 1'b0;
                end
            end
        endcase
        if (!s6_valid_reg)
        begin
            emit    = 1'b0;
            consume = 1'b0;
        end
        second_next = second_reg;
        if (consume)
            second_next = 1'b0;
        else if (emit && s6_mode_reg == MODE_TWO_IN)
            second_next = 1'b1;
    end

    assign adv = !s6_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
            if (out_load)
                m_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && emit)
        begin
            m_data_reg <= TDATA_W'({s6_tag_reg, sel_tri});
            m_last_reg <= sel_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_second_only_split: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (s6_valid_reg && s6_mode_reg == MODE_TWO_IN))
        else $error("second triangle pending without a split item");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tlast))
        else $error("first triangle of a split not followed by the second");

    a_second_shown: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> m_axis_tvalid)
        else $error("second triangle pending while output is empty");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triangle plane clipper.
// ----------------------------------------------------------------------------
// Triangles are streamed in with random gaps and random output back-pressure.
// A local copy of the plane registers predicts the clipped triangles for each
// accepted transaction. The checker compares every output transaction against
// the oldest predicted triangle.
module testbench;
    import tpc_pkg::*;

    localparam int CB      = 32;
    localparam int TB      = 24;
    localparam int TDW     = ((9 * CB + TB + 7) / 8) * 8;
    localparam int TFRAC   = 61 - CB;
    localparam int LATENCY = TFRAC + 8;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic [TB-1:0]    tag;
        logic [8:0][31:0] crd;
    } tri_t;

    typedef struct {
        logic [TDW-1:0] data;
        logic           last;
    } clip_out_t;

    logic clk;
    logic rst_n;
    logic [TDW-1:0] s_axis_tdata;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [TDW-1:0] m_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic m_axis_tlast;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    longint nx, ny, nz, doff;
    clip_out_t clipped_q[$];
    int errors;
    longint cycles;

    triangle_plane_clip_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint floor_div_pow(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint cut_t(longint d1, longint d2);
        longint num;
        longint den;
        num = d1 + (doff <<< 14);
        den = d1 - d2;
        if (den == 0)
            return longint'(1) <<< (TFRAC - 1);
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        if (num <= 0)
            return 0;
        if (num >= den)
            return longint'(1) <<< TFRAC;
        // num < den < 2^50, num * 2^29 fits in a 128-bit product
        return longint'((128'(num) << TFRAC) / 128'(den));
    endfunction

    function automatic void cut_point(input longint s[3], input longint e[3],
                                      input longint t, output longint o[3]);
        for (int k = 0; k < 3; k++)
            o[k] = s[k] + floor_div_pow(t * (e[k] - s[k])
                   + (longint'(1) <<< (TFRAC - 1)), TFRAC);
    endfunction

    function automatic void push_clipped(longint a[3], longint b[3], longint c[3],
                                         logic [TB-1:0] tag, logic last);
        clip_out_t r;
        tri_t t;
        for (int k = 0; k < 3; k++)
        begin
            t.crd[k]     = a[k][31:0];
            t.crd[3 + k] = b[k][31:0];
            t.crd[6 + k] = c[k][31:0];
        end
        t.tag = tag;
        r.data = TDW'(t);
        r.last = last;
        clipped_q.insert(clipped_q.size(), r);
    endfunction

    function automatic void predict_clip(tri_t t);
        longint v[3][3];
        longint dval[3];
        longint p1[3];
        longint p2[3];
        bit ins[3];
        int n;
        int a;
        int b;
        int c;
        bit one_in;
        n = 0;
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
                v[i][k] = longint'($signed(t.crd[i * 3 + k]));
            dval[i] = v[i][0] * nx + v[i][1] * ny + v[i][2] * nz;
            ins[i] = (dval[i] + (doff <<< 14)) >= 0;
            n += ins[i];
        end
        if (n == 0)
            return;
        if (n == 3)
        begin
            push_clipped(v[0], v[1], v[2], t.tag, 1'b1);
            return;
        end
        one_in = (n == 1);
        if (ins[0] == one_in)
        begin
            a = 0; b = 1; c = 2;
        end
        else if (ins[1] == one_in)
        begin
            a = 1; b = 2; c = 0;
        end
        else
        begin
            a = 2; b = 0; c = 1;
        end
        cut_point(v[a], v[b], cut_t(dval[a], dval[b]), p1);
        cut_point(v[c], v[a], cut_t(dval[c], dval[a]), p2);
        if (one_in)
            push_clipped(v[a], p1, p2, t.tag, 1'b1);
        else
        begin
            push_clipped(p1, v[b], v[c], t.tag, 1'b0);
            push_clipped(p1, v[c], p2, t.tag, 1'b1);
        end
    endfunction

    // Output side: random stall per transaction, compare with oldest prediction.
    initial
    begin
        int stall;
        clip_out_t exp_r;
        m_axis_tready = 1'b0;
        errors = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            if (clipped_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected triangle %h last %b", m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                exp_r = clipped_q.pop_front();
                if (exp_r.data !== m_axis_tdata || exp_r.last !== m_axis_tlast)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: expected %h last %b, got %h last %b",
                                 exp_r.data, exp_r.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_triangle(tri_t t);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= TDW'(t);
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_clip(t);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (clipped_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_NORMAL_X:     nx = longint'($signed(value[15:0]));
            REG_NORMAL_Y:     ny = longint'($signed(value[15:0]));
            REG_NORMAL_Z:     nz = longint'($signed(value[15:0]));
            REG_PLANE_OFFSET: doff = longint'($signed(value));
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_plane(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                             logic [31:0] d);
        drain_results();
        write_reg(REG_NORMAL_X, {16'($urandom), x});
        write_reg(REG_NORMAL_Y, {16'($urandom), y});
        write_reg(REG_NORMAL_Z, {16'($urandom), z});
        write_reg(REG_PLANE_OFFSET, d);
    endtask

    function automatic logic [31:0] rand_coord(int style);
        case (style)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
            2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    function automatic tri_t rand_triangle();
        tri_t t;
        int style;
        style = $urandom_range(0, 9);
        style = (style < 2) ? 0 : (style < 6) ? 1 : (style < 9) ? 2 : 3;
        for (int i = 0; i < 9; i++)
            t.crd[i] = ($urandom_range(0, 15) == 0) ? rand_coord(3) : rand_coord(style);
        t.tag = TB'($urandom);
        return t;
    endfunction

    function automatic tri_t make_tri(int ax, int bx, int cx, logic [TB-1:0] tag);
        tri_t t;
        t.crd = '0;
        t.crd[0] = ax <<< 16;
        t.crd[3] = bx <<< 16;
        t.crd[6] = cx <<< 16;
        t.crd[4] = 32'h0001_0000;
        t.crd[8] = 32'h0002_0000;
        t.tag = tag;
        return t;
    endfunction

    task automatic test_reset_plane();
        tri_t t;
        send_triangle(make_tri(1, 2, 3, 24'h000001));    // all inside
        send_triangle(make_tri(-1, -2, -3, 24'hffffff)); // all outside
        send_triangle(make_tri(1, -2, -3, 24'h000002));  // one inside
        send_triangle(make_tri(-1, 2, 3, 24'h000003));   // one outside
        send_triangle(make_tri(3, -1, 2, 24'h000004));   // odd vertex in middle
        send_triangle(make_tri(2, 3, -1, 24'h000005));   // odd vertex last
        send_triangle(make_tri(0, -1, -1, 24'h000006));  // on the plane counts inside
        t = '0;
        for (int i = 0; i < 9; i++)
            t.crd[i] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
        t.tag = 24'hffffff;
        send_triangle(t);
        t.crd[0] = 32'h80000000;
        t.crd[3] = 32'h7fffffff;
        t.crd[6] = 32'h80000000;
        send_triangle(t);
    endtask

    task automatic test_special_cuts();
        tri_t t;
        // Zero normal: all distances equal the offset, negative offset culls.
        set_plane(16'h0000, 16'h0000, 16'h0000, 32'hffff_0000);
        send_triangle(make_tri(1, -2, 3, 24'h000010));
        // Normal along z only: the x coordinates no longer matter and vertex B lies on the plane.
        set_plane(16'h0000, 16'h0000, 16'h4000, 32'h0000_0000);
        t = make_tri(1, -1, 1, 24'h000011);
        t.crd[2] = 32'hffff_0000;
        send_triangle(t);
        // Extreme normal and offset to reach saturation of the cut parameter.
        set_plane(16'h7fff, 16'h8000, 16'h7fff, 32'h7fffffff);
        send_triangle(rand_triangle());
        send_triangle(make_tri(-32768, 1, 32767, 24'h000012));
        set_plane(16'h8000, 16'h7fff, 16'h8000, 32'h80000000);
        send_triangle(make_tri(-32768, 1, 32767, 24'h000013));
        send_triangle(rand_triangle());
        // Unknown register index must be ignored.
        drain_results();
        write_reg(8'd4, 32'h1234_5678);
        write_reg(8'hff, 32'hffff_ffff);
        send_triangle(make_tri(5, -5, 0, 24'h000014));
    endtask

    task automatic test_random_planes();
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [31:0] d;
        for (int ph = 0; ph < 10; ph++)
        begin
            x = (ph % 3 == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 32768)) - 16384);
            y = (ph % 4 == 1) ? 16'h0000 : 16'($urandom);
            z = 16'($urandom);
            d = (ph % 2) ? $urandom : 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
            set_plane(x, y, z, d);
            for (int i = 0; i < 72; i++)
                send_triangle(rand_triangle());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cycles = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        nx = 16384;
        ny = 0;
        nz = 0;
        doff = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_plane();
        test_special_cuts();
        test_random_planes();
        drain_results();
        if (errors == 0 && clipped_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
